// ===== design/mcr_pkg.sv =====
// ============================================================================
// mcr_pkg
// Shared types and constants of the midpoint circle rasteriser: field widths,
// command codes, configuration register indexes and reset values.
// ============================================================================
package mcr_pkg;

    // Widths of the fixed-size fields.
    localparam int CLIP_W     = 13;
    localparam int ADDR_W     = 32;
    localparam int PITCH_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int DEC_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Depth of the job queue between the front and back parts (power of two).
    localparam int QUEUE_DEPTH = 4;

    // Command codes of an input beat.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Constants of the midpoint decision variable.
    localparam logic [DEC_W-1:0] DEC_INIT = 16'd3;
    localparam logic [DEC_W-1:0] DEC_BIAS = 16'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT   = 3'd0,
        CFG_CLIP_RIGHT  = 3'd1,
        CFG_CLIP_TOP    = 3'd2,
        CFG_CLIP_BOTTOM = 3'd3,
        CFG_FRAME_BASE  = 3'd4,
        CFG_LINE_PITCH  = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers.
    localparam logic signed [CLIP_W-1:0] CLIP_LEFT_RST   = 13'sd0;
    localparam logic signed [CLIP_W-1:0] CLIP_RIGHT_RST  = 13'sd639;
    localparam logic signed [CLIP_W-1:0] CLIP_TOP_RST    = 13'sd0;
    localparam logic signed [CLIP_W-1:0] CLIP_BOTTOM_RST = 13'sd479;
    localparam logic [ADDR_W-1:0]        FRAME_BASE_RST  = 32'd0;
    localparam logic [PITCH_W-1:0]       LINE_PITCH_RST  = 16'd1280;

    // Clip window handed from the register file to the pixel pipeline.
    typedef struct packed {
        logic signed [CLIP_W-1:0] left;
        logic signed [CLIP_W-1:0] right;
        logic signed [CLIP_W-1:0] top;
        logic signed [CLIP_W-1:0] bottom;
    } t_clip_win;

endpackage

// ===== design/mcr_queue.sv =====
// ============================================================================
// mcr_queue
// Small first-in first-out queue of jobs between the command front end and
// the pixel back end, built from flip-flops.
// ============================================================================
module mcr_queue #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    // Handshake decode.
    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== design/mcr_front.sv =====
// ============================================================================
// mcr_front
// Command front end: takes start and step beats, keeps the circle state and
// the midpoint decision variable, and queues one job per beat that yields
// pixels.
// ============================================================================
module mcr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_cmd,
    input  logic signed [COORD_BITS-1:0]    i_center_x,
    input  logic signed [COORD_BITS-1:0]    i_center_y,
    input  logic signed [COORD_BITS-1:0]    i_radius,
    input  logic [mcr_pkg::COLOR_W-1:0]     i_color,
    output logic                            o_job_valid,
    input  logic                            i_job_ready,
    output logic [2+4*COORD_BITS+mcr_pkg::COLOR_W-1:0] o_job_data
);

    localparam int C     = COORD_BITS;
    localparam int DEC_W = mcr_pkg::DEC_W;

    typedef struct packed {
        logic                            single;
        logic                            done;
        logic signed [C-1:0]             cx;
        logic signed [C-1:0]             cy;
        logic [C-1:0]                    major;
        logic [C-1:0]                    minor;
        logic [mcr_pkg::COLOR_W-1:0]     color;
    } t_job;

    logic signed [C-1:0]         r_centre_col;
    logic signed [C-1:0]         r_centre_row;
    logic [mcr_pkg::COLOR_W-1:0] r_pen_color;
    logic [C-1:0]                r_major;
    logic [C-1:0]                r_minor;
    logic [DEC_W-1:0]            r_dec;
    logic                        r_active;

    logic                        accept;
    logic [C-1:0]                mag;
    logic                        mag_zero;
    logic                        mag_one;
    logic [DEC_W-1:0]            dec_init;
    logic [C-1:0]                minor_next;
    logic [C-1:0]                major_next;
    logic [DEC_W-1:0]            four_minor;
    logic [DEC_W-1:0]            four_major;
    logic [DEC_W-1:0]            dec_next;
    logic                        step_done;
    t_job                        job;

    assign o_ready = i_job_ready;
    assign accept  = i_valid && i_job_ready;

    // Radius magnitude; the most negative value keeps its bit pattern.
    always_comb begin
        mag      = i_radius[C-1] ? C'(~i_radius + 1'b1) : C'(i_radius);
        mag_zero = (mag == '0);
        mag_one  = (mag == C'(1));
        dec_init = mcr_pkg::DEC_INIT - DEC_W'({mag, 1'b0});
    end

    // One midpoint step: the minor offset always advances, the major offset
    // only when the decision variable is not negative.
    always_comb begin
        minor_next = r_minor + 1'b1;
        major_next = r_dec[DEC_W-1] ? r_major : r_major - 1'b1;
        four_minor = DEC_W'({minor_next, 2'b00});
        four_major = DEC_W'({major_next, 2'b00});
        if (r_dec[DEC_W-1]) begin
            dec_next = r_dec + four_minor + mcr_pkg::DEC_BIAS;
        end else begin
            dec_next = r_dec - four_major + four_minor + mcr_pkg::DEC_BIAS;
        end
        step_done = (major_next < minor_next);
    end

    // Job built from the current beat.
    always_comb begin
        job         = '0;
        o_job_valid = 1'b0;
        case (i_cmd)
            mcr_pkg::CMD_START: begin
                job.single  = 1'b1;
                job.done    = 1'b1;
                job.cx      = i_center_x;
                job.cy      = i_center_y;
                job.color   = i_color;
                o_job_valid = i_valid && mag_one;
            end
            mcr_pkg::CMD_STEP: begin
                o_job_valid = i_valid;
                if (r_active) begin
                    job.done  = step_done;
                    job.cx    = r_centre_col;
                    job.cy    = r_centre_row;
                    job.major = r_major;
                    job.minor = r_minor;
                    job.color = r_pen_color;
                end else begin
                    job.single = 1'b1;
                    job.done   = 1'b1;
                end
            end
            default: begin
                job = '0;
            end
        endcase
    end

    assign o_job_data = job;

    // Circle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_col <= '0;
            r_centre_row <= '0;
            r_pen_color  <= '0;
            r_major      <= '0;
            r_minor      <= '0;
            r_dec        <= '0;
            r_active     <= 1'b0;
        end else if (accept) begin
            case (i_cmd)
                mcr_pkg::CMD_START: begin
                    r_centre_col <= i_center_x;
                    r_centre_row <= i_center_y;
                    r_pen_color  <= i_color;
                    r_active     <= !(mag_zero || mag_one);
                    if (!(mag_zero || mag_one)) begin
                        r_major <= mag;
                        r_minor <= '0;
                        r_dec   <= dec_init;
                    end
                end
                mcr_pkg::CMD_STEP: begin
                    if (r_active) begin
                        r_major  <= major_next;
                        r_minor  <= minor_next;
                        r_dec    <= dec_next;
                        r_active <= !step_done;
                    end
                end
                default: begin
                    r_active <= r_active;
                end
            endcase
        end
    end

endmodule

// ===== design/mcr_back.sv =====
// ============================================================================
// mcr_back
// Pixel back end: expands each queued job into one or eight mirrored pixels
// and runs them through a three-stage pipeline (generate, multiply and clip,
// address sum) into the output register.
// ============================================================================
module mcr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mcr_pkg::t_clip_win                 i_clip,
    input  logic [mcr_pkg::ADDR_W-1:0]         i_frame_base,
    input  logic [mcr_pkg::PITCH_W-1:0]        i_line_pitch,
    input  logic                               i_job_valid,
    output logic                               o_job_ready,
    input  logic [2+4*COORD_BITS+mcr_pkg::COLOR_W-1:0] i_job_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [COORD_BITS:0]         o_pixel_x,
    output logic signed [COORD_BITS:0]         o_pixel_y,
    output logic [mcr_pkg::ADDR_W-1:0]         o_pixel_address,
    output logic [mcr_pkg::COLOR_W-1:0]        o_pixel_color,
    output logic                               o_write_enable,
    output logic                               o_last,
    output logic                               o_done_res
);

    localparam int C      = COORD_BITS;
    localparam int PIX_W  = COORD_BITS + 1;
    localparam int ADDR_W = mcr_pkg::ADDR_W;
    localparam int CLIP_W = mcr_pkg::CLIP_W;
    localparam int PROD_W = PIX_W + mcr_pkg::PITCH_W + 1;
    localparam int EXT_W  = ADDR_W + PROD_W;
    localparam int CMP_W  = ((PIX_W > CLIP_W) ? PIX_W : CLIP_W) + 1;

    typedef struct packed {
        logic                            single;
        logic                            done;
        logic signed [C-1:0]             cx;
        logic signed [C-1:0]             cy;
        logic [C-1:0]                    major;
        logic [C-1:0]                    minor;
        logic [mcr_pkg::COLOR_W-1:0]     color;
    } t_job;

    t_job                         head;
    logic [2:0]                   r_k;
    logic                         last_pix;
    logic                         gen_fire;
    logic                         can_g;
    logic                         can_p;
    logic                         can_o;
    logic signed [PIX_W-1:0]      cx_e;
    logic signed [PIX_W-1:0]      cy_e;
    logic signed [PIX_W-1:0]      off_x;
    logic signed [PIX_W-1:0]      off_y;
    logic signed [PIX_W-1:0]      gen_x;
    logic signed [PIX_W-1:0]      gen_y;

    // Generate stage registers.
    logic                         r_g_valid;
    logic signed [PIX_W-1:0]      r_g_x;
    logic signed [PIX_W-1:0]      r_g_y;
    logic [mcr_pkg::COLOR_W-1:0]  r_g_color;
    logic                         r_g_last;
    logic                         r_g_done;

    // Multiply and clip stage registers.
    logic                         r_p_valid;
    logic signed [PIX_W-1:0]      r_p_x;
    logic signed [PIX_W-1:0]      r_p_y;
    logic signed [PROD_W-1:0]     r_p_prod;
    logic                         r_p_we;
    logic [mcr_pkg::COLOR_W-1:0]  r_p_color;
    logic                         r_p_last;
    logic                         r_p_done;

    // Output registers.
    logic                         r_o_valid;
    logic signed [PIX_W-1:0]      r_o_x;
    logic signed [PIX_W-1:0]      r_o_y;
    logic [ADDR_W-1:0]            r_o_addr;
    logic [mcr_pkg::COLOR_W-1:0]  r_o_color;
    logic                         r_o_we;
    logic                         r_o_last;
    logic                         r_o_done;

    logic signed [PROD_W-1:0]     prod;
    logic signed [CMP_W-1:0]      xc;
    logic signed [CMP_W-1:0]      yc;
    logic                         we;
    logic signed [EXT_W-1:0]      prod_ext;
    logic signed [ADDR_W-1:0]     x_ext;
    logic [ADDR_W-1:0]            addr;

    // Stage advance: a stage moves on when the one after it is free or moving.
    assign can_o = !r_o_valid || i_ready;
    assign can_p = !r_p_valid || can_o;
    assign can_g = !r_g_valid || can_p;

    // Pixel selection from the job at the head of the queue. Bit 1 of the
    // pixel counter swaps the offsets, bit 0 mirrors the column and bit 2
    // mirrors the row.
    always_comb begin
        head     = t_job'(i_job_data);
        last_pix = head.single || (r_k == 3'd7);
        gen_fire = i_job_valid && can_g;
        cx_e     = PIX_W'(head.cx);
        cy_e     = PIX_W'(head.cy);
        off_x    = $signed({1'b0, (r_k[1] ? head.minor : head.major)});
        off_y    = $signed({1'b0, (r_k[1] ? head.major : head.minor)});
        gen_x    = r_k[0] ? cx_e - off_x : cx_e + off_x;
        gen_y    = r_k[2] ? cy_e - off_y : cy_e + off_y;
    end

    assign o_job_ready = gen_fire && last_pix;

    // Generate stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_g_valid <= 1'b0;
        end else if (can_g) begin
            r_g_valid <= gen_fire;
            if (gen_fire) begin
                r_k <= last_pix ? 3'd0 : r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (gen_fire) begin
            r_g_x     <= gen_x;
            r_g_y     <= gen_y;
            r_g_color <= head.color;
            r_g_last  <= last_pix;
            r_g_done  <= head.done;
        end
    end

    // Row offset product and clip window test.
    always_comb begin
        prod = r_g_y * $signed({1'b0, i_line_pitch});
        xc   = CMP_W'(r_g_x);
        yc   = CMP_W'(r_g_y);
        we   = (xc >= CMP_W'(i_clip.left)) && (xc <= CMP_W'(i_clip.right)) &&
               (yc >= CMP_W'(i_clip.top))  && (yc <= CMP_W'(i_clip.bottom));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (can_p) begin
            r_p_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_p && r_g_valid) begin
            r_p_x     <= r_g_x;
            r_p_y     <= r_g_y;
            r_p_prod  <= prod;
            r_p_we    <= we;
            r_p_color <= r_g_color;
            r_p_last  <= r_g_last;
            r_p_done  <= r_g_done;
        end
    end

    // Byte address, wrapping modulo the address width.
    always_comb begin
        prod_ext = EXT_W'(r_p_prod);
        x_ext    = ADDR_W'(r_p_x);
        addr     = i_frame_base + prod_ext[ADDR_W-1:0] + {x_ext[ADDR_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (can_o) begin
            r_o_valid <= r_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_o && r_p_valid) begin
            r_o_x     <= r_p_x;
            r_o_y     <= r_p_y;
            r_o_addr  <= addr;
            r_o_color <= r_p_color;
            r_o_we    <= r_p_we;
            r_o_last  <= r_p_last;
            r_o_done  <= r_p_done;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_pixel_x       = r_o_x;
    assign o_pixel_y       = r_o_y;
    assign o_pixel_address = r_o_addr;
    assign o_pixel_color   = r_o_color;
    assign o_write_enable  = r_o_we;
    assign o_last          = r_o_last;
    assign o_done_res      = r_o_done;

endmodule

// ===== design/midpoint_circle_rasterizer_core.sv =====
// ============================================================================
// midpoint_circle_rasterizer_core
// Midpoint circle rasteriser with a clip window and frame-buffer addressing.
// ============================================================================
// Usage:
// Input beats arrive on i_valid/o_ready. A start beat (i_cmd low) loads the
// centre, the magnitude of the radius and the colour; a radius of one yields
// the centre pixel alone and a radius of zero yields nothing. Each step beat
// yields the eight mirrored pixels of the next octant point, or a single
// idle pixel marked done when no circle is active.
// Pixel beats leave on o_valid/i_ready, one per cycle at most; the back end's
// pixel counter walks the eight pixels of a step one after another. The front
// end accepts one beat per cycle while its 4-entry job queue has room. The
// first pixel of a beat passes the job queue and the generate, multiply and
// clip and output registers, and leaves no earlier than the following edge.
// When the receiver stalls, the pipeline and queue fill and o_ready drops.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while the
// block is idle. Synchronous reset clears the queue, the pipeline and the
// active circle, and restores the register defaults.
// ============================================================================
module midpoint_circle_rasterizer_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mcr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mcr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic signed [COORD_BITS-1:0]        i_center_x,
    input  logic signed [COORD_BITS-1:0]        i_center_y,
    input  logic signed [COORD_BITS-1:0]        i_radius,
    input  logic [mcr_pkg::COLOR_W-1:0]         i_color,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [COORD_BITS:0]          o_pixel_x,
    output logic signed [COORD_BITS:0]          o_pixel_y,
    output logic [mcr_pkg::ADDR_W-1:0]          o_pixel_address,
    output logic [mcr_pkg::COLOR_W-1:0]         o_pixel_color,
    output logic                                o_write_enable,
    output logic                                o_last,
    output logic                                o_done_res
);

    localparam int JOB_W = 2 + 4 * COORD_BITS + mcr_pkg::COLOR_W;

    mcr_pkg::t_clip_win                 r_clip;
    logic [mcr_pkg::ADDR_W-1:0]         r_frame_base;
    logic [mcr_pkg::PITCH_W-1:0]        r_line_pitch;

    logic                               push_valid;
    logic                               push_ready;
    logic [JOB_W-1:0]                   push_data;
    logic                               pop_valid;
    logic                               pop_ready;
    logic [JOB_W-1:0]                   pop_data;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip.left   <= mcr_pkg::CLIP_LEFT_RST;
            r_clip.right  <= mcr_pkg::CLIP_RIGHT_RST;
            r_clip.top    <= mcr_pkg::CLIP_TOP_RST;
            r_clip.bottom <= mcr_pkg::CLIP_BOTTOM_RST;
            r_frame_base  <= mcr_pkg::FRAME_BASE_RST;
            r_line_pitch  <= mcr_pkg::LINE_PITCH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mcr_pkg::CFG_CLIP_LEFT: begin
                    r_clip.left <= $signed(i_cfg_data[mcr_pkg::CLIP_W-1:0]);
                end
                mcr_pkg::CFG_CLIP_RIGHT: begin
                    r_clip.right <= $signed(i_cfg_data[mcr_pkg::CLIP_W-1:0]);
                end
                mcr_pkg::CFG_CLIP_TOP: begin
                    r_clip.top <= $signed(i_cfg_data[mcr_pkg::CLIP_W-1:0]);
                end
                mcr_pkg::CFG_CLIP_BOTTOM: begin
                    r_clip.bottom <= $signed(i_cfg_data[mcr_pkg::CLIP_W-1:0]);
                end
                mcr_pkg::CFG_FRAME_BASE: begin
                    r_frame_base <= i_cfg_data[mcr_pkg::ADDR_W-1:0];
                end
                mcr_pkg::CFG_LINE_PITCH: begin
                    r_line_pitch <= i_cfg_data[mcr_pkg::PITCH_W-1:0];
                end
                default: begin
                    r_line_pitch <= r_line_pitch;
                end
            endcase
        end
    end

    // Command front end.
    mcr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .i_color     (i_color),
        .o_job_valid (push_valid),
        .i_job_ready (push_ready),
        .o_job_data  (push_data)
    );

    // Job queue.
    mcr_queue #(
        .WIDTH (JOB_W),
        .DEPTH (mcr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    // Pixel back end.
    mcr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clip          (r_clip),
        .i_frame_base    (r_frame_base),
        .i_line_pitch    (r_line_pitch),
        .i_job_valid     (pop_valid),
        .o_job_ready     (pop_ready),
        .i_job_data      (pop_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_write_enable  (o_write_enable),
        .o_last          (o_last),
        .o_done_res      (o_done_res)
    );

endmodule

// ===== verif/midpoint_circle_rasterizer_core_tb.sv =====
// ============================================================================
// midpoint_circle_rasterizer_core_tb
// Self-checking bench for the midpoint circle rasteriser. Start and step beats
// are sent with random gaps while the pixel side stalls at random. Each
// accepted beat is run through a behavioural circle generator that queues the
// pixels it should produce, and every pixel beat is checked field by field
// against the oldest queued pixel.
// ============================================================================
module midpoint_circle_rasterizer_core_tb;

    localparam int COORD_W        = 12;
    localparam int RANDOM_BEATS   = 410;
    localparam int RANDOM_PHASES  = 6;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 5000;

    // Indexes past the end of the register map; writes to them must be ignored.
    localparam logic [mcr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [mcr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // One pixel beat as it should leave the block.
    typedef struct packed {
        logic signed [COORD_W:0]         x;
        logic signed [COORD_W:0]         y;
        logic [mcr_pkg::ADDR_W-1:0]      address;
        logic [mcr_pkg::COLOR_W-1:0]     color;
        logic                            we;
        logic                            last;
        logic                            done;
    } t_pixel;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [mcr_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [mcr_pkg::CFG_DATA_W-1:0]     i_cfg_data  = '0;
    logic                               i_valid     = 1'b0;
    logic                               o_ready;
    logic                               i_cmd       = mcr_pkg::CMD_START;
    logic signed [COORD_W-1:0]          i_center_x  = '0;
    logic signed [COORD_W-1:0]          i_center_y  = '0;
    logic signed [COORD_W-1:0]          i_radius    = '0;
    logic [mcr_pkg::COLOR_W-1:0]        i_color     = '0;
    logic                               o_valid;
    logic                               i_ready     = 1'b0;
    logic signed [COORD_W:0]            o_pixel_x;
    logic signed [COORD_W:0]            o_pixel_y;
    logic [mcr_pkg::ADDR_W-1:0]         o_pixel_address;
    logic [mcr_pkg::COLOR_W-1:0]        o_pixel_color;
    logic                               o_write_enable;
    logic                               o_last;
    logic                               o_done_res;

    // Mirror of the configuration registers.
    int                           clip_left   = 0;
    int                           clip_right  = 639;
    int                           clip_top    = 0;
    int                           clip_bottom = 479;
    logic [mcr_pkg::ADDR_W-1:0]   frame_base  = mcr_pkg::FRAME_BASE_RST;
    logic [mcr_pkg::PITCH_W-1:0]  line_pitch  = mcr_pkg::LINE_PITCH_RST;

    // Mirror of the circle in progress.
    int                           centre_col = 0;
    int                           centre_row = 0;
    logic [mcr_pkg::COLOR_W-1:0]  pen        = '0;
    int                           major      = 0;
    int                           minor      = 0;
    logic signed [15:0]           decision   = '0;
    bit                           circle_on  = 1'b0;

    t_pixel pending_pixels[$];
    int     mismatches   = 0;
    int     beats_sent   = 0;
    int     no_gap_beats = 0;
    int     quiet_cycles = 0;

    midpoint_circle_rasterizer_core #(
        .COORD_BITS(COORD_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_address(o_pixel_address),
        .o_pixel_color  (o_pixel_color),
        .o_write_enable (o_write_enable),
        .o_last         (o_last),
        .o_done_res     (o_done_res)
    );

    // Clock with a period of four units.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Queue one pixel with its clip test and wrapped byte address.
    function automatic void push_pixel(int x, int y, logic [mcr_pkg::COLOR_W-1:0] col,
                                       bit last, bit done);
        t_pixel p;
        longint addr;
        addr = longint'({32'd0, frame_base}) + longint'(y) * longint'({48'd0, line_pitch})
             + 2 * longint'(x);
        p.x       = x[COORD_W:0];
        p.y       = y[COORD_W:0];
        p.address = addr[mcr_pkg::ADDR_W-1:0];
        p.color   = col;
        p.we      = (x >= clip_left) && (x <= clip_right) && (y >= clip_top) && (y <= clip_bottom);
        p.last    = last;
        p.done    = done;
        pending_pixels.push_back(p);
    endfunction

    // Work out the pixels that one accepted beat produces and advance the circle.
    function automatic void rasterize_beat(input logic cmd,
                                           input logic signed [COORD_W-1:0] cx, cy, rad,
                                           input logic [mcr_pkg::COLOR_W-1:0] col);
        int     r;
        int     d;
        int     maj;
        int     mnr;
        int     xs[8];
        int     ys[8];
        bit     fin;
        if (cmd == mcr_pkg::CMD_START) begin
            r = rad;
            if (r < 0) r = -r;
            centre_col = cx;
            centre_row = cy;
            pen        = col;
            circle_on  = 1'b0;
            if (r == 1) begin
                push_pixel(centre_col, centre_row, pen, 1'b1, 1'b1);
            end else if (r > 1) begin
                major     = r;
                minor     = 0;
                decision  = 16'(3 - 2 * r);
                circle_on = 1'b1;
            end
        end else if (!circle_on) begin
            // A step with no circle gives a single blank pixel at the origin, marked
            // done; its address and clip test still follow the current settings.
            push_pixel(0, 0, '0, 1'b1, 1'b1);
        end else begin
            maj = major;
            mnr = minor;
            d   = decision;
            xs = '{centre_col + maj, centre_col - maj, centre_col + mnr, centre_col - mnr,
                   centre_col + maj, centre_col - maj, centre_col + mnr, centre_col - mnr};
            ys = '{centre_row + mnr, centre_row + mnr, centre_row + maj, centre_row + maj,
                   centre_row - mnr, centre_row - mnr, centre_row - maj, centre_row - maj};
            if (d < 0) begin
                mnr = mnr + 1;
                d   = d + 4 * mnr + 2;
            end else begin
                mnr = mnr + 1;
                maj = maj - 1;
                d   = d - 4 * maj + 4 * mnr + 2;
            end
            decision  = 16'(d);
            major     = maj & 12'hFFF;
            minor     = mnr & 12'hFFF;
            fin       = maj < mnr;
            circle_on = !fin;
            for (int k = 0; k < 8; k++) begin
                push_pixel(xs[k], ys[k], pen, k == 7, fin);
            end
        end
    endfunction

    // Send one input beat after a random gap and predict its pixels on acceptance.
    task automatic send_beat(input logic cmd, input logic signed [COORD_W-1:0] cx, cy, rad,
                             input logic [mcr_pkg::COLOR_W-1:0] col);
        int gap;
        if (no_gap_beats > 0) begin
            no_gap_beats--;
            gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
            no_gap_beats = $urandom_range(8, 30);
            gap = 0;
        end else begin
            gap = idle_len();
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= rad;
        i_color    <= col;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        beats_sent++;
        rasterize_beat(cmd, cx, cy, rad, col);
    endtask

    // A step beat carries junk in the fields the block ignores.
    task automatic step_circle();
        send_beat(mcr_pkg::CMD_STEP, COORD_W'($urandom()), COORD_W'($urandom()),
                  COORD_W'($urandom()), mcr_pkg::COLOR_W'($urandom()));
    endtask

    task automatic finish_circle();
        while (circle_on) step_circle();
    endtask

    // Stop sending and wait until every queued pixel has left and the pipe is empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the enable is left high for a following write.
    task automatic cfg_write(input logic [mcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mcr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            mcr_pkg::CFG_CLIP_LEFT:   clip_left   = $signed(data[mcr_pkg::CLIP_W-1:0]);
            mcr_pkg::CFG_CLIP_RIGHT:  clip_right  = $signed(data[mcr_pkg::CLIP_W-1:0]);
            mcr_pkg::CFG_CLIP_TOP:    clip_top    = $signed(data[mcr_pkg::CLIP_W-1:0]);
            mcr_pkg::CFG_CLIP_BOTTOM: clip_bottom = $signed(data[mcr_pkg::CLIP_W-1:0]);
            mcr_pkg::CFG_FRAME_BASE:  frame_base  = data;
            mcr_pkg::CFG_LINE_PITCH:  line_pitch  = data[mcr_pkg::PITCH_W-1:0];
            default: ;
        endcase
    endtask

    // Write all six registers; the unused upper data bits carry junk.
    task automatic program_regs(input int l, r, t, b, input logic [mcr_pkg::ADDR_W-1:0] base,
                                input logic [mcr_pkg::PITCH_W-1:0] pitch);
        logic [31:0] junk;
        junk = $urandom();
        cfg_write(mcr_pkg::CFG_CLIP_LEFT,   {junk[31:13], l[12:0]});
        cfg_write(mcr_pkg::CFG_CLIP_RIGHT,  {junk[31:13], r[12:0]});
        cfg_write(mcr_pkg::CFG_CLIP_TOP,    {junk[31:13], t[12:0]});
        cfg_write(mcr_pkg::CFG_CLIP_BOTTOM, {junk[31:13], b[12:0]});
        cfg_write(mcr_pkg::CFG_FRAME_BASE,  base);
        cfg_write(mcr_pkg::CFG_LINE_PITCH,  {junk[31:16], pitch});
        i_cfg_we <= 1'b0;
    endtask

    // Idle steps, an empty circle and single-pixel circles under reset settings.
    task automatic test_idle_and_tiny();
        step_circle();
        send_beat(mcr_pkg::CMD_START, 12'sd100, 12'sd100, 12'sd0, 16'h1234);
        step_circle();
        send_beat(mcr_pkg::CMD_START, -12'sd3, 12'sd200, 12'sd1, 16'hFFFF);
        send_beat(mcr_pkg::CMD_START, 12'sd639, 12'sd479, -12'sd1, 16'h0000);
    endtask

    // A small circle straddling the bottom of the reset window, then one step too many.
    task automatic test_default_window_circle();
        send_beat(mcr_pkg::CMD_START, 12'sd2, 12'sd477, 12'sd6, 16'hA5A5);
        finish_circle();
        step_circle();
    endtask

    // Writes past the end of the register map must leave the settings unchanged.
    task automatic test_spare_index();
        drain();
        cfg_write(CFG_SPARE_LO, '1);
        cfg_write(CFG_SPARE_HI, $urandom());
        i_cfg_we <= 1'b0;
        send_beat(mcr_pkg::CMD_START, 12'sd320, 12'sd240, -12'sd5, 16'h5A5A);
        finish_circle();
    endtask

    // Widest window with wrapping addresses, extreme centres and radii, then a
    // one-pixel window with a zero pitch.
    task automatic test_extreme_settings();
        drain();
        program_regs(-4096, 4095, -4096, 4095, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(mcr_pkg::CMD_START, -12'sd2048, -12'sd2048, -12'sd2048, 16'hFFFF);
        repeat (3) step_circle();
        // A new start abandons the circle in progress.
        send_beat(mcr_pkg::CMD_START, 12'sd2047, 12'sd2047, 12'sd2047, 16'h0000);
        repeat (2) step_circle();
        drain();
        program_regs(10, 10, 10, 10, 32'd0, 16'd0);
        send_beat(mcr_pkg::CMD_START, 12'sd10, 12'sd8, 12'sd2, 16'h8001);
        finish_circle();
    endtask

    // Random window and addressing for one phase of the random traffic.
    task automatic program_random_window();
        int          l;
        int          r;
        int          t;
        int          b;
        logic [31:0] base;
        logic [15:0] pitch;
        case ($urandom_range(0, 3))
            0: begin
                l = -4096; r = 4095; t = -4096; b = 4095;
            end
            1: begin
                l = $urandom_range(0, 8191) - 4096;
                r = $urandom_range(0, 8191) - 4096;
                t = $urandom_range(0, 8191) - 4096;
                b = $urandom_range(0, 8191) - 4096;
            end
            default: begin
                l = $urandom_range(0, 600) - 300;
                r = l + $urandom_range(0, 700);
                t = $urandom_range(0, 600) - 300;
                b = t + $urandom_range(0, 700);
            end
        endcase
        case ($urandom_range(0, 3))
            0:       base = 32'hFFFF_FFFF;
            1:       base = 32'd0;
            default: base = $urandom();
        endcase
        case ($urandom_range(0, 3))
            0:       pitch = 16'hFFFF;
            1:       pitch = 16'd0;
            default: pitch = 16'($urandom_range(0, 4096));
        endcase
        program_regs(l, r, t, b, base, pitch);
    endtask

    // Mostly whole circles with random content; some abandoned, some noise beats.
    task automatic random_circle();
        int rad;
        int mag;
        int cx;
        int cy;
        int steps_left;
        if ($urandom_range(0, 3) == 0) begin
            send_beat(1'($urandom_range(0, 1)), COORD_W'($urandom()), COORD_W'($urandom()),
                      COORD_W'($urandom()), mcr_pkg::COLOR_W'($urandom()));
            return;
        end
        case ($urandom_range(0, 9))
            0:       rad = $urandom_range(0, 1);
            1:       rad = $urandom_range(100, 2047);
            2:       rad = 2048;
            default: rad = $urandom_range(2, 24);
        endcase
        mag = rad;
        if ($urandom_range(0, 1) == 1) rad = -rad;
        if ($urandom_range(0, 1) == 1) begin
            cx = $urandom_range(0, 700) - 100;
            cy = $urandom_range(0, 560) - 80;
        end else begin
            cx = $urandom_range(0, 4095) - 2048;
            cy = $urandom_range(0, 4095) - 2048;
        end
        send_beat(mcr_pkg::CMD_START, COORD_W'(cx), COORD_W'(cy), COORD_W'(rad),
                  mcr_pkg::COLOR_W'($urandom()));
        if (mag > 40 || $urandom_range(0, 5) == 0) steps_left = $urandom_range(0, 6);
        else steps_left = 4096;
        while (circle_on && steps_left > 0) begin
            step_circle();
            steps_left--;
        end
        repeat ($urandom_range(0, 2)) step_circle();
    endtask

    // Several phases of random traffic, each under its own settings.
    task automatic test_random_traffic();
        int first;
        first = beats_sent;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            program_random_window();
            while (beats_sent < first + (phase + 1) * RANDOM_BEATS / RANDOM_PHASES) begin
                random_circle();
            end
        end
    endtask

    // Pixel side: runs of ready with random stalls between them.
    initial begin : ready_driver
        int run_len;
        int stall;
        forever begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 19) == 0) run_len = $urandom_range(60, 150);
            else run_len = $urandom_range(1, 12);
            repeat (run_len) @(posedge i_clk);
            stall = idle_len();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Compare each pixel beat with the oldest expected pixel.
    always @(posedge i_clk) begin : check_pixels
        t_pixel want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with none expected: x=%0d y=%0d", o_pixel_x, o_pixel_y);
                mismatches++;
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_x !== want.x) begin
                    $error("pixel_x: expected %0d, got %0d", want.x, o_pixel_x);
                    mismatches++;
                end
                if (o_pixel_y !== want.y) begin
                    $error("pixel_y: expected %0d, got %0d", want.y, o_pixel_y);
                    mismatches++;
                end
                if (o_pixel_address !== want.address) begin
                    $error("pixel_address: expected %h, got %h", want.address, o_pixel_address);
                    mismatches++;
                end
                if (o_pixel_color !== want.color) begin
                    $error("pixel_color: expected %h, got %h", want.color, o_pixel_color);
                    mismatches++;
                end
                if (o_write_enable !== want.we) begin
                    $error("write_enable: expected %b, got %b", want.we, o_write_enable);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, o_last);
                    mismatches++;
                end
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %b, got %b", want.done, o_done_res);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: too long without any beat or register write ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_and_tiny();
        test_default_window_circle();
        test_spare_index();
        test_extreme_settings();
        test_random_traffic();
        drain();
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
